// ----- hw/rtl/shortest_path_edge_relaxation_unit_macros.svh -----
// Assertion macros for the shortest path edge relaxation unit checker.
// Included by the checker file; it has no other dependencies.
`ifndef SHORTEST_PATH_EDGE_RELAXATION_UNIT_MACROS_SVH
`define SHORTEST_PATH_EDGE_RELAXATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define SPR_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spr_pkg.sv -----
// Shared types and constants for the shortest path edge relaxation unit.
// No dependencies; imported by the top level.
package spr_pkg;

  // Fixed field widths of the item and result channels.
  localparam int NODE_W     = 12;
  localparam int WEIGHT_W   = 32;
  localparam int OUT_COST_W = 48;
  localparam int WIDE_W     = 64;

  // Configuration port: one 32-bit register, word index taken from paddr[2].
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SOURCE = 1'b0;

  // Search epoch tag kept with every cost entry; tag zero never matches.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = EPOCH_W'(0);

  // Item commands.
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RELAX = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

endpackage

// ----- hw/rtl/shortest_path_edge_relaxation_unit.sv -----
// Shortest path edge relaxation unit: node cost table with relax, start and query items.
// Depends on spr_pkg and spr_cost_mem.
//
// Usage: items arrive on the in_ channel (valid/stall) carrying a command, two node
// indexes and a signed weight. Each item gives exactly one result on the out_ channel:
// improved, node_cost (the to-node cost after the item, all ones but the sign bit
// meaning unreached) and reportable. The source node is set over the APB-style port
// (register 0 at byte address 0) and must only be written while the unit is idle.
// At the accepting edge both node entries are read from memory; the saturating add is
// registered in the calc state, and the compare, write-back and result register follow
// in the write state. No new item is accepted until the current one has left the write
// state, which waits while the output is stalled.
// Each cost entry carries an 8-bit search tag, so a start advances the tag and writes
// the source entry instead of clearing the table. Every 255th start wraps the tag and
// sweeps the memory. After reset the same sweep runs, with in_stall high.
// When the receiver stalls, the result stays in the output register; the unit
// still accepts and processes the next item, which then waits for the output.
module shortest_path_edge_relaxation_unit #(
  parameter int NODE_COUNT = 4096,
  parameter int COST_BITS  = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Item channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic [spr_pkg::NODE_W-1:0]        in_from_node,
  input  logic [spr_pkg::NODE_W-1:0]        in_to_node,
  input  logic signed [spr_pkg::WEIGHT_W-1:0] in_weight,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_improved,
  output logic signed [spr_pkg::OUT_COST_W-1:0] out_node_cost,
  output logic                              out_reportable,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [spr_pkg::PADDR_W-1:0]       paddr,
  input  logic [spr_pkg::PDATA_W-1:0]       pwdata,
  output logic [spr_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  import spr_pkg::*;

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int MEM_W  = EPOCH_W + COST_BITS;
  localparam int SUM_W  = ((COST_BITS > WEIGHT_W) ? COST_BITS : WEIGHT_W) + 1;
  localparam logic signed [COST_BITS-1:0] COST_MAX = {1'b0, {(COST_BITS-1){1'b1}}};
  localparam logic signed [COST_BITS-1:0] COST_MIN = {1'b1, {(COST_BITS-1){1'b0}}};
  localparam logic signed [COST_BITS-1:0] COST_ZERO = '0;
  localparam logic signed [SUM_W-1:0] SAT_TOP = SUM_W'(COST_MAX) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_BOT = SUM_W'(COST_MIN);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(NODE_COUNT - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_WRITE
  } state_t;

  // True when a node index lies inside the table.
  function automatic logic node_in_range(logic [NODE_W-1:0] n);
    return 32'(n) < 32'(NODE_COUNT);
  endfunction

  // Sign-extend or truncate a cost to the result width.
  function automatic logic signed [OUT_COST_W-1:0] to_out_cost(
    logic signed [COST_BITS-1:0] c
  );
    logic signed [WIDE_W-1:0] wide;
    wide = WIDE_W'(c);
    return wide[OUT_COST_W-1:0];
  endfunction

  // Control registers.
  state_t              state_r, state_nxt;
  logic [EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                pend_start_r, pend_start_nxt;
  logic [NODE_W-1:0]   source_r, source_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Payload registers.
  cmd_t                        cmd_r, cmd_nxt;
  logic [NODE_W-1:0]           to_r, to_nxt;
  logic                        from_in_r, from_in_nxt;
  logic                        to_in_r, to_in_nxt;
  logic signed [WEIGHT_W-1:0]  weight_r, weight_nxt;
  logic signed [COST_BITS-1:0] cand_r, cand_nxt;
  logic                        from_ok_r, from_ok_nxt;
  logic                        to_ok_r, to_ok_nxt;
  logic                        out_improved_r, out_improved_nxt;
  logic signed [OUT_COST_W-1:0] out_cost_r, out_cost_nxt;
  logic                        out_report_r, out_report_nxt;

  // Memory interface.
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [MEM_W-1:0]  mem_wr_data;
  logic              mem_rd_en;
  logic [MEM_W-1:0]  rd_from;
  logic [MEM_W-1:0]  rd_to;

  // Datapath signals.
  logic                        accept;
  logic                        cfg_wr;
  logic                        finish;
  logic                        src_in;
  logic signed [COST_BITS-1:0] from_cost;
  logic signed [COST_BITS-1:0] to_cost;
  logic signed [SUM_W-1:0]     sum;
  logic signed [COST_BITS-1:0] sat_sum;
  logic                        better;
  logic                        relax_wr;
  logic                        start_wr;
  logic signed [COST_BITS-1:0] res_cost;
  logic                        res_improved;
  logic                        res_report;

  spr_cost_mem #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (ADDR_W),
    .DATA_W (MEM_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_en     (mem_rd_en),
    .rd_addr_a (ADDR_W'(in_from_node)),
    .rd_addr_b (ADDR_W'(in_to_node)),
    .rd_data_a (rd_from),
    .rd_data_b (rd_to)
  );

  // Handshakes and configuration access.
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign finish   = !out_valid_r || !out_stall;
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_SOURCE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_SOURCE) ? PDATA_W'(source_r) : '0;
  assign src_in   = node_in_range(source_r);

  // Saturating add of the from-node cost and the weight.
  assign from_cost = rd_from[COST_BITS-1:0];
  assign to_cost   = rd_to[COST_BITS-1:0];
  assign sum       = SUM_W'(from_cost) + SUM_W'(weight_r);

  always_comb begin
    if (sum > SAT_TOP) begin
      sat_sum = COST_BITS'(SAT_TOP);
    end else if (sum < SAT_BOT) begin
      sat_sum = COST_BITS'(SAT_BOT);
    end else begin
      sat_sum = COST_BITS'(sum);
    end
  end

  // Compare and write decisions in the write-back cycle.
  assign better   = !to_ok_r || (cand_r < to_cost);
  assign relax_wr = (cmd_r == CMD_RELAX) && from_ok_r && to_in_r && better;
  assign start_wr = (cmd_r == CMD_START) && src_in;

  // Result of the item in the write-back cycle.
  always_comb begin
    res_improved = 1'b0;
    res_report   = 1'b0;
    res_cost     = COST_ZERO;
    case (cmd_r)
      CMD_START: begin
        res_cost = (src_in && (to_r == source_r)) ? COST_ZERO : COST_MAX;
      end
      CMD_RELAX: begin
        if (relax_wr) begin
          res_cost     = cand_r;
          res_improved = 1'b1;
        end else begin
          res_cost = to_ok_r ? to_cost : COST_MAX;
        end
      end
      CMD_QUERY: begin
        res_cost   = to_ok_r ? to_cost : COST_MAX;
        res_report = to_ok_r && (to_r != source_r);
      end
      default: begin
        res_cost = COST_ZERO;
      end
    endcase
  end

  // Memory port control: sweep writes during clear, else the write-back.
  always_comb begin
    mem_rd_en = accept;
    if (state_r == ST_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_cnt_r;
      mem_wr_data = {EPOCH_NONE, COST_ZERO};
    end else begin
      mem_wr_en   = (state_r == ST_WRITE) && finish && (relax_wr || start_wr);
      mem_wr_addr = (cmd_r == CMD_START) ? ADDR_W'(source_r) : ADDR_W'(to_r);
      mem_wr_data = {epoch_r, (cmd_r == CMD_START) ? COST_ZERO : cand_r};
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt        = state_r;
    epoch_nxt        = epoch_r;
    clr_cnt_nxt      = clr_cnt_r;
    pend_start_nxt   = pend_start_r;
    source_nxt       = cfg_wr ? pwdata[NODE_W-1:0] : source_r;
    out_valid_nxt    = out_valid_r && out_stall;
    cmd_nxt          = cmd_r;
    to_nxt           = to_r;
    from_in_nxt      = from_in_r;
    to_in_nxt        = to_in_r;
    weight_nxt       = weight_r;
    cand_nxt         = cand_r;
    from_ok_nxt      = from_ok_r;
    to_ok_nxt        = to_ok_r;
    out_improved_nxt = out_improved_r;
    out_cost_nxt     = out_cost_r;
    out_report_nxt   = out_report_r;

    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == CLR_LAST) begin
          clr_cnt_nxt    = '0;
          epoch_nxt      = EPOCH_FIRST;
          pend_start_nxt = 1'b0;
          state_nxt      = pend_start_r ? ST_WRITE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = cmd_t'(in_command);
          to_nxt      = in_to_node;
          from_in_nxt = node_in_range(in_from_node);
          to_in_nxt   = node_in_range(in_to_node);
          weight_nxt  = in_weight;
          state_nxt   = ST_CALC;
          if (in_command == CMD_START) begin
            if (epoch_r == EPOCH_LAST) begin
              pend_start_nxt = 1'b1;
              state_nxt      = ST_CLEAR;
            end else begin
              epoch_nxt = epoch_r + EPOCH_W'(1);
            end
          end
        end
      end
      ST_CALC: begin
        from_ok_nxt = from_in_r && (rd_from[MEM_W-1:COST_BITS] == epoch_r);
        to_ok_nxt   = to_in_r && (rd_to[MEM_W-1:COST_BITS] == epoch_r);
        cand_nxt    = sat_sum;
        state_nxt   = ST_WRITE;
      end
      ST_WRITE: begin
        if (finish) begin
          out_valid_nxt    = 1'b1;
          out_improved_nxt = res_improved;
          out_cost_nxt     = to_out_cost(res_cost);
          out_report_nxt   = res_report;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      epoch_r      <= EPOCH_FIRST;
      clr_cnt_r    <= '0;
      pend_start_r <= 1'b0;
      source_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      epoch_r      <= epoch_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      pend_start_r <= pend_start_nxt;
      source_r     <= source_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r          <= cmd_nxt;
    to_r           <= to_nxt;
    from_in_r      <= from_in_nxt;
    to_in_r        <= to_in_nxt;
    weight_r       <= weight_nxt;
    cand_r         <= cand_nxt;
    from_ok_r      <= from_ok_nxt;
    to_ok_r        <= to_ok_nxt;
    out_improved_r <= out_improved_nxt;
    out_cost_r     <= out_cost_nxt;
    out_report_r   <= out_report_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_improved   = out_improved_r;
  assign out_node_cost  = out_cost_r;
  assign out_reportable = out_report_r;

endmodule

// ----- hw/rtl/spr_cost_mem.sv -----
// Node cost memory: one synchronous write port and two registered read ports.
// Standalone; instantiated by the top level.
module spr_cost_mem #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 56
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- hw/rtl/spr_checker.sv -----
// Port-level checker for the shortest path edge relaxation unit, with its bind.
// Depends on the macro header and on the top level it binds to.
`include "shortest_path_edge_relaxation_unit_macros.svh"

module spr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_improved,
  input logic [47:0] out_node_cost,
  input logic        out_reportable
);

  // A stalled result holds its payload.
  `SPR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_node_cost) && $stable(out_improved) && $stable(out_reportable), "stalled result changed")

  // Only a relax improves and only a query reports, so never both.
  `SPR_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(out_improved && out_reportable), "improved and reportable both set")

  // An accepted item occupies the unit for at least the following cycle.
  `SPR_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall, "item accepted while one is in flight")

  // Reset empties the output and starts the memory sweep.
  `SPR_ASSERT_NXT_ALWAYS(a_reset_state, clk, !rst_n, !out_valid && in_stall, "reset did not clear the unit")

endmodule

bind shortest_path_edge_relaxation_unit spr_checker u_spr_checker (.*);
